// ===== src/pmt_pkg.sv =====
package pmt_pkg;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_SCAN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    // move number prefix scan: digits, then dots, then a new group
    typedef enum logic [3:0] {
        P_DIG0 = 4'b0001,
        P_DIG  = 4'b0010,
        P_DOT  = 4'b0100,
        P_DONE = 4'b1000
    } t_phase;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [2:0] LEN_WIN  = 3'd3;
    localparam logic [2:0] LEN_DRAW = 3'd7;
    localparam logic [2:0] LEN_STAR = 3'd1;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

    // "1-0"
    function automatic logic white_ok(input logic [2:0] k, input logic [7:0] c);
        logic ok;
        unique case (k)
            3'd0: ok = (c == CH_ONE);
            3'd1: ok = (c == CH_DASH);
            3'd2: ok = (c == CH_ZERO);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    // "0-1"
    function automatic logic black_ok(input logic [2:0] k, input logic [7:0] c);
        logic ok;
        unique case (k)
            3'd0: ok = (c == CH_ZERO);
            3'd1: ok = (c == CH_DASH);
            3'd2: ok = (c == CH_ONE);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    // "1/2-1/2"
    function automatic logic draw_ok(input logic [2:0] k, input logic [7:0] c);
        logic ok;
        unique case (k)
            3'd0: ok = (c == CH_ONE);
            3'd1: ok = (c == CH_SLASH);
            3'd2: ok = (c == CH_TWO);
            3'd3: ok = (c == CH_DASH);
            3'd4: ok = (c == CH_ONE);
            3'd5: ok = (c == CH_SLASH);
            3'd6: ok = (c == CH_TWO);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// ===== src/pmt_ram.sv =====
module pmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/pgn_movetext_tokenizer_unit.sv =====
// Movetext tokenizer: takes one character per request and returns the move tokens it
// contains, one character per request with an end marker on the last, skipping comments,
// variations, move numbers, annotations, NAGs and results. A character that closes a
// token keeps the input stalled, so that no further character is taken, while the block
// sets up the buffer read, makes one scan step per buffered character through the single
// read port of the token buffer plus a final decision step, and emits each kept
// character, waiting out any output stall. Characters past MAX_TOKEN_CHARS are dropped
// and the token is flagged.
module pgn_movetext_tokenizer_unit
    import pmt_pkg::*;
#(
    parameter int MAX_TOKEN_CHARS = 16,
    parameter int MAX_NEST_LEVEL  = 15
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_text_valid,
    output logic       o_text_stall,
    input  logic [7:0] i_text_char,
    input  logic       i_text_last,
    output logic       o_token_valid,
    input  logic       i_token_stall,
    output logic [7:0] o_token_char,
    output logic       o_token_end,
    output logic       o_token_truncated
);

    localparam int AW = $clog2(MAX_TOKEN_CHARS);
    localparam int PW = $clog2(MAX_TOKEN_CHARS + 1);
    localparam int NW = $clog2(MAX_NEST_LEVEL + 1);
    localparam logic [PW-1:0] FILL_MAX = PW'(MAX_TOKEN_CHARS);
    localparam logic [NW-1:0] NEST_MAX = NW'(MAX_NEST_LEVEL);
    localparam logic [PW-1:0] PTR_ONE  = PW'(1);
    localparam logic [NW-1:0] NEST_ONE = NW'(1);

    t_state        r_state, n_state;
    logic          r_line, n_line;
    logic          r_brace, n_brace;
    logic [NW-1:0] r_nest, n_nest;
    logic [PW-1:0] r_fill, n_fill;
    logic          r_ovf, n_ovf;
    logic [PW-1:0] r_ptr, n_ptr;
    logic [PW-1:0] r_start, n_start;
    logic          r_o_valid, n_o_valid;

    t_phase        r_phase, n_phase;
    logic [2:0]    r_rel, n_rel;
    logic          r_any_dot, n_any_dot;
    logic          r_only_num, n_only_num;
    logic          r_only_ann, n_only_ann;
    logic          r_dollar, n_dollar;
    logic          r_star, n_star;
    logic          r_mw, n_mw;
    logic          r_mb, n_mb;
    logic          r_md, n_md;
    logic [7:0]    r_o_char, n_o_char;
    logic          r_o_end, n_o_end;
    logic          r_o_trunc, n_o_trunc;

    logic          accept;
    logic          c_wr, c_close, c_ovf_set;
    logic          c_line, c_brace;
    logic [NW-1:0] c_nest;
    logic [PW-1:0] fill_after;
    logic [7:0]    rdata;
    logic          restart;
    logic [2:0]    rel_b;
    logic          keep;
    logic          load;
    logic          emit_end;

    pmt_ram #(
        .WIDTH(8),
        .DEPTH(MAX_TOKEN_CHARS)
    ) u_buf (
        .i_clk  (i_clk),
        .i_we   (accept && c_wr),
        .i_waddr(r_fill[AW-1:0]),
        .i_wdata(i_text_char),
        .i_raddr(n_ptr[AW-1:0]),
        .o_rdata(rdata)
    );

    assign accept       = (r_state == S_IDLE) && i_text_valid;
    assign o_text_stall = (r_state != S_IDLE);

    // character classification against the current mode
    always_comb begin
        c_wr      = 1'b0;
        c_close   = 1'b0;
        c_ovf_set = 1'b0;
        c_line    = r_line;
        c_brace   = r_brace;
        c_nest    = r_nest;
        if (r_line) begin
            if ((i_text_char == CH_LF) || (i_text_char == CH_CR)) begin
                c_line = 1'b0;
            end
        end else if (r_brace) begin
            if (i_text_char == CH_RBRACE) begin
                c_brace = 1'b0;
            end
        end else if (r_nest != '0) begin
            if (i_text_char == CH_LBRACE) begin
                c_brace = 1'b1;
            end else if (i_text_char == CH_SEMI) begin
                c_line = 1'b1;
            end else if (i_text_char == CH_LPAREN) begin
                if (r_nest < NEST_MAX) begin
                    c_nest = r_nest + NEST_ONE;
                end
            end else if (i_text_char == CH_RPAREN) begin
                c_nest = r_nest - NEST_ONE;
            end
        end else if (i_text_char == CH_LBRACE) begin
            c_close = 1'b1;
            c_brace = 1'b1;
        end else if (i_text_char == CH_SEMI) begin
            c_close = 1'b1;
            c_line  = 1'b1;
        end else if (i_text_char == CH_LPAREN) begin
            c_close = 1'b1;
            c_nest  = NEST_ONE;
        end else if (is_space(i_text_char)) begin
            c_close = 1'b1;
        end else if (r_fill < FILL_MAX) begin
            c_wr = 1'b1;
        end else begin
            c_ovf_set = 1'b1;
        end
    end

    assign fill_after = r_fill + PW'(c_wr);
    assign emit_end   = ((r_ptr + PTR_ONE) == r_fill);
    assign load       = !r_o_valid || !i_token_stall;

    // prefix stripping restarts the token after each digits-and-dots group
    always_comb begin
        restart = 1'b0;
        n_phase = r_phase;
        unique case (r_phase)
            P_DIG0: n_phase = is_digit(rdata) ? P_DIG : P_DONE;
            P_DIG: begin
                if (is_digit(rdata)) begin
                    n_phase = P_DIG;
                end else if (rdata == CH_DOT) begin
                    n_phase = P_DOT;
                end else begin
                    n_phase = P_DONE;
                end
            end
            P_DOT: begin
                if (rdata != CH_DOT) begin
                    restart = 1'b1;
                    n_phase = is_digit(rdata) ? P_DIG : P_DONE;
                end
            end
            P_DONE: n_phase = P_DONE;
            default: n_phase = P_DONE;
        endcase
    end

    assign rel_b = restart ? 3'd0 : r_rel;

    assign keep = (r_phase != P_DOT) && (r_rel != 3'd0) && !r_dollar &&
                  !(r_only_num && r_any_dot) && !r_only_ann &&
                  !(r_mw && (r_rel == LEN_WIN)) && !(r_mb && (r_rel == LEN_WIN)) &&
                  !(r_md && (r_rel == LEN_DRAW)) && !(r_star && (r_rel == LEN_STAR));

    always_comb begin
        n_state    = r_state;
        n_line     = r_line;
        n_brace    = r_brace;
        n_nest     = r_nest;
        n_fill     = r_fill;
        n_ovf      = r_ovf;
        n_ptr      = r_ptr;
        n_start    = r_start;
        n_o_valid  = r_o_valid && i_token_stall;
        n_rel      = r_rel;
        n_any_dot  = r_any_dot;
        n_only_num = r_only_num;
        n_only_ann = r_only_ann;
        n_dollar   = r_dollar;
        n_star     = r_star;
        n_mw       = r_mw;
        n_mb       = r_mb;
        n_md       = r_md;
        n_o_char   = r_o_char;
        n_o_end    = r_o_end;
        n_o_trunc  = r_o_trunc;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_line  = c_line && !i_text_last;
                    n_brace = c_brace && !i_text_last;
                    n_nest  = i_text_last ? '0 : c_nest;
                    n_fill  = fill_after;
                    n_ovf   = r_ovf || c_ovf_set;
                    if (c_close || i_text_last) begin
                        if (fill_after != '0) begin
                            n_state = S_PREP;
                        end else begin
                            n_fill = '0;
                            n_ovf  = 1'b0;
                        end
                    end
                end
            end
            S_PREP: begin
                n_ptr      = '0;
                n_start    = '0;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                if (r_ptr != r_fill) begin
                    n_ptr = r_ptr + PTR_ONE;
                    if (restart) begin
                        n_start = r_ptr;
                    end
                    n_rel      = (rel_b == 3'd7) ? 3'd7 : rel_b + 3'd1;
                    n_any_dot  = (restart ? 1'b0 : r_any_dot) || (rdata == CH_DOT);
                    n_only_num = (restart ? 1'b1 : r_only_num) &&
                                 ((rdata == CH_DOT) || is_digit(rdata));
                    n_only_ann = (restart ? 1'b1 : r_only_ann) &&
                                 ((rdata == CH_BANG) || (rdata == CH_QUEST));
                    n_mw       = (restart ? 1'b1 : r_mw) && white_ok(rel_b, rdata);
                    n_mb       = (restart ? 1'b1 : r_mb) && black_ok(rel_b, rdata);
                    n_md       = (restart ? 1'b1 : r_md) && draw_ok(rel_b, rdata);
                    if (rel_b == 3'd0) begin
                        n_dollar = (rdata == CH_DOLLAR);
                        n_star   = (rdata == CH_STAR);
                    end
                end else if (keep) begin
                    n_ptr   = r_start;
                    n_state = S_EMIT;
                end else begin
                    n_fill  = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (load) begin
                    n_o_valid = 1'b1;
                    n_o_char  = rdata;
                    n_o_end   = emit_end;
                    n_o_trunc = r_ovf;
                    n_ptr     = r_ptr + PTR_ONE;
                    if (emit_end) begin
                        n_fill  = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // scan flags and phase start fresh for each token
    t_phase scan_phase;
    always_comb begin
        scan_phase = r_phase;
        if (r_state == S_PREP) begin
            scan_phase = P_DIG0;
        end else if ((r_state == S_SCAN) && (r_ptr != r_fill)) begin
            scan_phase = n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_line    <= 1'b0;
            r_brace   <= 1'b0;
            r_nest    <= '0;
            r_fill    <= '0;
            r_ovf     <= 1'b0;
            r_ptr     <= '0;
            r_start   <= '0;
            r_o_valid <= 1'b0;
            r_phase   <= P_DIG0;
        end else begin
            r_state   <= n_state;
            r_line    <= n_line;
            r_brace   <= n_brace;
            r_nest    <= n_nest;
            r_fill    <= n_fill;
            r_ovf     <= n_ovf;
            r_ptr     <= n_ptr;
            r_start   <= n_start;
            r_o_valid <= n_o_valid;
            r_phase   <= scan_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PREP) begin
            r_rel      <= 3'd0;
            r_any_dot  <= 1'b0;
            r_only_num <= 1'b1;
            r_only_ann <= 1'b1;
            r_dollar   <= 1'b0;
            r_star     <= 1'b0;
            r_mw       <= 1'b1;
            r_mb       <= 1'b1;
            r_md       <= 1'b1;
        end else begin
            r_rel      <= n_rel;
            r_any_dot  <= n_any_dot;
            r_only_num <= n_only_num;
            r_only_ann <= n_only_ann;
            r_dollar   <= n_dollar;
            r_star     <= n_star;
            r_mw       <= n_mw;
            r_mb       <= n_mb;
            r_md       <= n_md;
        end
        r_o_char  <= n_o_char;
        r_o_end   <= n_o_end;
        r_o_trunc <= n_o_trunc;
    end

    assign o_token_valid     = r_o_valid;
    assign o_token_char      = r_o_char;
    assign o_token_end       = r_o_end;
    assign o_token_truncated = r_o_trunc;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("token fill beyond buffer");

    a_nest_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nest <= NEST_MAX)
        else $error("variation depth beyond bound");

    a_emit_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_ptr < r_fill))
        else $error("emit pointer past buffered token");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_text_last) |=> (!r_line && !r_brace && (r_nest == '0)))
        else $error("mode state not cleared after last character");

    a_rose_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_token_valid) |-> ($past(r_state) == S_EMIT))
        else $error("token request raised outside emit");
`endif

endmodule
